// ===== hw/rtl/dlfb_pkg.sv =====
// shared types and constants for the dense layer forward/backward engine
// no dependencies
package dlfb_pkg;

    localparam int MAX_EMIT = 16;

    typedef enum logic [2:0] {
        ACT_LOAD_W   = 3'd0,
        ACT_LOAD_B   = 3'd1,
        ACT_FORWARD  = 3'd2,
        ACT_BACKWARD = 3'd3,
        ACT_READ     = 3'd4,
        ACT_CLEAR    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        KIND_FWD   = 2'd0,
        KIND_IGRAD = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_MAC,
        ST_FWD_OUT,
        ST_BWD_STEP,
        ST_BWD_BIAS,
        ST_IG_OUT,
        ST_READ,
        ST_CLEAR,
        ST_INIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;    // latch the accepted item
        logic       store_item; // write loads / forward element
        logic       fwd_mac;    // forward multiply-accumulate step
        logic       fwd_emit;   // forward output ready
        logic       bwd_step;   // backward column step
        logic       bwd_bias;   // bias gradient update
        logic       ig_emit;    // input gradient output
        logic       rd_emit;    // gradient readout output
        logic       clr_step;   // clearing sweep step
        logic       cnt_clear;  // reset the step counter
        logic       cnt_inc;    // advance step counter
    } dlfb_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       slot_ok;
        logic       row_ok;
        logic       last;
        logic       cnt_end_in;
        logic       cnt_end_out;
        logic       cnt_end_clr;
        logic       cnt_end_emit_in;
        logic       cnt_end_emit_out;
        logic       pipe_busy;
        logic       out_free;
    } dlfb_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -48'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/dlfb_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module dlfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/dlfb_ctrl.sv =====
// controller state machine for the dense layer engine
// depends on dlfb_pkg
module dlfb_ctrl
    import dlfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dlfb_stat_t stat,
    output dlfb_cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.clr_step = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_end_clr) begin
                    cmd.cnt_clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = !stat.pipe_busy;
                if (s_tvalid && s_tready) begin
                    cmd.capture = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.pipe_busy) begin
                    // item captured last cycle: dispatch
                    case (stat.action)
                        ACT_LOAD_W, ACT_LOAD_B: begin
                            cmd.store_item = 1'b1;
                        end
                        ACT_FORWARD: begin
                            cmd.store_item = 1'b1;
                            if (stat.slot_ok && stat.last)
                                state_next = ST_FWD_MAC;
                        end
                        ACT_BACKWARD: begin
                            if (stat.slot_ok && stat.row_ok)
                                state_next = ST_BWD_STEP;
                            else if (stat.last)
                                state_next = ST_IG_OUT;
                            else
                                cmd.store_item = 1'b1;
                        end
                        ACT_READ: state_next = ST_READ;
                        ACT_CLEAR: begin
                            cmd.store_item = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default: cmd.store_item = 1'b1;
                    endcase
                end
            end
            ST_FWD_MAC: begin
                cmd.fwd_mac = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_end_in) begin
                    cmd.cnt_clear = 1'b1;
                    state_next = ST_FWD_OUT;
                end
            end
            ST_FWD_OUT: begin
                if (stat.out_free) begin
                    cmd.fwd_emit = 1'b1;
                    if (stat.cnt_end_emit_out) begin
                        cmd.store_item = 1'b1;
                        state_next = ST_IDLE;
                    end else
                        state_next = ST_FWD_MAC;
                end
            end
            ST_BWD_STEP: begin
                cmd.bwd_step = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_end_in) begin
                    cmd.cnt_clear = 1'b1;
                    state_next = ST_BWD_BIAS;
                end
            end
            ST_BWD_BIAS: begin
                cmd.bwd_bias = 1'b1;
                if (stat.last)
                    state_next = ST_IG_OUT;
                else begin
                    cmd.store_item = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_IG_OUT: begin
                if (stat.out_free) begin
                    cmd.ig_emit = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (stat.cnt_end_emit_in) begin
                        cmd.store_item = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                cmd.cnt_inc = 1'b1;
                if (stat.out_free && stat.cnt_end_emit_in) begin
                    cmd.rd_emit = 1'b1;
                    cmd.store_item = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_end_clr) begin
                    cmd.cnt_clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // no new item while a captured one is still in work
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.pipe_busy |-> !s_tready) else $error("accept while busy");
    a_emit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.fwd_emit, cmd.ig_emit, cmd.rd_emit}) <= 1)
        else $error("two emits at once");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fwd_emit || cmd.ig_emit || cmd.rd_emit) |-> stat.out_free)
        else $error("emit into full output");
endmodule

// ===== hw/rtl/dlfb_datapath.sv =====
// datapath: stores, mac unit, gradient accumulators and output register
// depends on dlfb_pkg and dlfb_ram
module dlfb_datapath
    import dlfb_pkg::*;
#(
    parameter int IN_SIZE     = 16,
    parameter int OUT_SIZE    = 16,
    parameter int BATCH_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  dlfb_cmd_t   cmd,
    output dlfb_stat_t  stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    localparam int IW  = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int OW  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int SW  = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
    localparam int WD  = OUT_SIZE * IN_SIZE;
    localparam int WAW = $clog2(WD + 1);
    localparam int XD  = BATCH_SLOTS * IN_SIZE;
    localparam int XAW = $clog2(XD + 1);
    localparam int CW  = $clog2(WD + 2) + 1;
    localparam int IGN = (IN_SIZE < MAX_EMIT) ? IN_SIZE : MAX_EMIT;
    localparam int FON = (OUT_SIZE < MAX_EMIT) ? OUT_SIZE : MAX_EMIT;

    // captured item
    logic [2:0]         act_reg;
    logic [2:0]         slot_reg;
    logic [3:0]         row_reg, col_reg;
    logic signed [15:0] val_reg;
    logic               rbias_reg, last_reg, busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            busy_reg <= 1'b0;
        else if (cmd.capture)
            busy_reg <= 1'b1;
        else if (cmd.store_item)
            busy_reg <= 1'b0;
        if (cmd.capture) begin
            act_reg   <= s_tdata[2:0];
            slot_reg  <= s_tdata[5:3];
            row_reg   <= s_tdata[9:6];
            col_reg   <= s_tdata[13:10];
            val_reg   <= s_tdata[29:14];
            rbias_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    logic slot_ok, row_ok, col_ok;
    assign slot_ok = 32'(slot_reg) < BATCH_SLOTS;
    assign row_ok  = 32'(row_reg) < OUT_SIZE;
    assign col_ok  = 32'(col_reg) < IN_SIZE;

    // step counter; j holds the forward output row
    logic [CW-1:0] cnt_reg;
    logic [OW:0]   j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            j_reg <= '0;
        end else begin
            if (cmd.cnt_clear) cnt_reg <= '0;
            else if (cmd.cnt_inc || cmd.fwd_mac) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.capture) j_reg <= '0;
            else if (cmd.fwd_emit) j_reg <= j_reg + 1'b1;
        end
    end

    // mac pipeline: address from cnt, read data registered in the ram, product registered after it
    // phase: cnt runs on to IN_SIZE+1 for pipeline drain
    logic [IW-1:0] k_addr;
    assign k_addr = cnt_reg[IW-1:0];
    logic in_phase;
    assign in_phase = 32'(cnt_reg) < IN_SIZE;

    // memories
    logic          w_we;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [15:0]   w_rdata;
    logic          b_we;
    logic [15:0]   b_rdata;
    logic          x_we;
    logic [XAW-1:0] x_waddr, x_raddr;
    logic [15:0]   x_rdata;
    logic          wg_we;
    logic [WAW-1:0] wg_waddr, wg_raddr;
    logic [31:0]   wg_wdata, wg_rdata;
    logic          bg_we;
    logic [OW-1:0] bg_waddr, bg_raddr;
    logic [31:0]   bg_wdata, bg_rdata;

    logic [OW-1:0] wrow;
    always_comb begin
        if (act_reg == ACT_FORWARD) wrow = j_reg[OW-1:0];
        else wrow = row_reg[OW-1:0];
    end

    assign w_we    = cmd.store_item && act_reg == ACT_LOAD_W && row_ok && col_ok;
    assign w_waddr = WAW'(32'(row_reg) * IN_SIZE + 32'(col_reg));
    assign w_raddr = WAW'(32'(wrow) * IN_SIZE + 32'(k_addr));
    assign b_we    = cmd.store_item && act_reg == ACT_LOAD_B && row_ok;
    assign x_we    = cmd.store_item && act_reg == ACT_FORWARD && slot_ok && col_ok;
    assign x_waddr = XAW'(32'(slot_reg) * IN_SIZE + 32'(col_reg));
    assign x_raddr = XAW'(32'(slot_reg) * IN_SIZE + 32'(k_addr));

    dlfb_ram #(.WIDTH(16), .DEPTH(WD)) u_w (.aclk, .we(w_we), .waddr(w_waddr[$clog2(WD)-1:0]),
        .wdata(val_reg), .raddr(w_raddr[$clog2(WD)-1:0]), .rdata(w_rdata));
    dlfb_ram #(.WIDTH(16), .DEPTH(OUT_SIZE)) u_b (.aclk, .we(b_we),
        .waddr(row_reg[$clog2(OUT_SIZE)-1:0]), .wdata(val_reg),
        .raddr(j_reg[$clog2(OUT_SIZE)-1:0]), .rdata(b_rdata));
    dlfb_ram #(.WIDTH(16), .DEPTH(XD)) u_x (.aclk, .we(x_we), .waddr(x_waddr[$clog2(XD)-1:0]),
        .wdata(val_reg), .raddr(x_raddr[$clog2(XD)-1:0]), .rdata(x_rdata));
    dlfb_ram #(.WIDTH(32), .DEPTH(WD)) u_wg (.aclk, .we(wg_we),
        .waddr(wg_waddr[$clog2(WD)-1:0]), .wdata(wg_wdata),
        .raddr(wg_raddr[$clog2(WD)-1:0]), .rdata(wg_rdata));
    dlfb_ram #(.WIDTH(32), .DEPTH(OUT_SIZE)) u_bg (.aclk, .we(bg_we),
        .waddr(bg_waddr), .wdata(bg_wdata), .raddr(bg_raddr), .rdata(bg_rdata));

    // pipeline tracking of the mac
    logic          v1_reg, v2_reg;
    logic [IW-1:0] k1_reg, k2_reg;
    logic signed [31:0] px_reg, pw_reg;
    logic signed [31:0] wg_old_reg;
    logic signed [47:0] facc_reg;
    logic signed [31:0] igacc [IN_SIZE];

    wire step = cmd.fwd_mac || cmd.bwd_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= step && in_phase;
            v2_reg <= v1_reg;
        end
        k1_reg <= k_addr;
        k2_reg <= k1_reg;
        if (act_reg == ACT_FORWARD)
            px_reg <= 32'(signed'(w_rdata)) * 32'(signed'(x_rdata));
        else
            px_reg <= 32'(val_reg) * 32'(signed'(x_rdata));
        pw_reg <= 32'(val_reg) * 32'(signed'(w_rdata));
        wg_old_reg <= wg_rdata;
        if (cmd.capture || cmd.fwd_emit)
            facc_reg <= '0;
        else if (v2_reg && act_reg == ACT_FORWARD)
            facc_reg <= facc_reg + 48'(px_reg);
    end

    // weight gradient read goes with the operand read, write comes at the k2/v2 stage
    assign wg_raddr = cmd.rd_emit || act_reg == ACT_READ
                      ? WAW'(32'(row_reg[OW-1:0]) * IN_SIZE + 32'(col_reg[IW-1:0]))
                      : WAW'(32'(row_reg[OW-1:0]) * IN_SIZE + 32'(k_addr));
    logic [31:0] wg_sum;
    assign wg_sum = sat32(48'(wg_old_reg) + 48'(px_reg >>> 8));
    always_comb begin
        wg_we = 1'b0;
        wg_waddr = WAW'(32'(row_reg[OW-1:0]) * IN_SIZE + 32'(k2_reg));
        wg_wdata = wg_sum;
        if (cmd.clr_step) begin
            wg_we = 32'(cnt_reg) < WD;
            wg_waddr = cnt_reg[WAW-1:0];
            wg_wdata = '0;
        end else if (v2_reg && act_reg == ACT_BACKWARD)
            wg_we = 1'b1;
    end
    assign bg_raddr = row_reg[OW-1:0];
    always_comb begin
        bg_we = 1'b0;
        bg_waddr = row_reg[OW-1:0];
        bg_wdata = sat32(48'(signed'(bg_rdata)) + 48'(val_reg));
        if (cmd.clr_step) begin
            bg_we = 32'(cnt_reg) < OUT_SIZE;
            bg_waddr = cnt_reg[OW-1:0];
            bg_wdata = '0;
        end else if (cmd.bwd_bias)
            bg_we = 1'b1;
    end

    // input gradient accumulators, one per column
    always_ff @(posedge aclk) begin
        for (int i = 0; i < IN_SIZE; i++) begin
            if (!aresetn)
                igacc[i] <= '0;
            else if (cmd.ig_emit && cnt_reg == CW'(IGN - 1))
                igacc[i] <= '0;
            else if (v2_reg && act_reg == ACT_BACKWARD && k2_reg == IW'(i))
                igacc[i] <= sat32(48'(igacc[i]) + 48'(pw_reg >>> 8));
        end
    end

    // output register
    logic        ov_reg, olast_reg;
    logic [1:0]  okind_reg;
    logic [3:0]  oidx_reg;
    logic [31:0] oval_reg;
    logic [31:0] rd_val;
    logic [31:0] fsum;

    assign fsum = sat32((facc_reg >>> 8) + 48'(signed'(b_rdata)));
    always_comb begin
        rd_val = '0;
        if (rbias_reg) begin
            if (row_ok) rd_val = bg_rdata;
        end else if (row_ok && col_ok)
            rd_val = wg_rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            ov_reg <= 1'b0;
        else if (cmd.fwd_emit || cmd.ig_emit || cmd.rd_emit)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
        if (cmd.fwd_emit) begin
            okind_reg <= KIND_FWD;
            oidx_reg  <= 4'(j_reg);
            oval_reg  <= fsum;
            olast_reg <= 32'(j_reg) == FON - 1;
        end else if (cmd.ig_emit) begin
            okind_reg <= KIND_IGRAD;
            oidx_reg  <= cnt_reg[3:0];
            oval_reg  <= igacc[k_addr];
            olast_reg <= cnt_reg == CW'(IGN - 1);
        end else if (cmd.rd_emit) begin
            okind_reg <= KIND_READ;
            oidx_reg  <= rbias_reg ? row_reg : col_reg;
            oval_reg  <= rd_val;
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, okind_reg, oidx_reg, oval_reg};
    assign m_tlast  = olast_reg;

    always_comb begin
        stat.action           = act_reg;
        stat.slot_ok          = slot_ok;
        stat.row_ok           = row_ok;
        stat.last             = last_reg;
        stat.cnt_end_in       = cnt_reg == CW'(IN_SIZE + 1);
        stat.cnt_end_out      = 1'b0;
        stat.cnt_end_clr      = cnt_reg == CW'(WD);
        stat.cnt_end_emit_in  = cnt_reg >= CW'(IGN - 1) || act_reg == ACT_READ
                                && cnt_reg >= CW'(1);
        stat.cnt_end_emit_out = 32'(j_reg) == FON - 1;
        stat.pipe_busy        = busy_reg;
        stat.out_free         = !ov_reg || m_tready;
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !m_tready |=> ov_reg) else $error("result dropped");
    a_mac_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> $past(v1_reg)) else $error("mac pipeline slip");
    a_clr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !v2_reg) else $error("clear during mac");
endmodule

// ===== hw/rtl/dense_layer_forward_backward.sv =====
// Dense layer forward/backward engine in Q8.8 with 32-bit saturating sums.
// After reset the gradient stores are cleared by a sweep over every address
// with input held off; a clear action takes the same sweep. A forward last
// element runs a MAC sweep over the inputs for each of min(OUT_SIZE,16) output
// rows, with output stalls between rows; a valid backward element runs one sweep,
// the MAC pipeline walking one column per cycle through the memory ports; a last
// backward element adds min(IN_SIZE,16) input gradient outputs. Depends on
// dlfb_pkg, dlfb_ctrl, dlfb_datapath and dlfb_ram.
module dense_layer_forward_backward
    import dlfb_pkg::*;
#(
    parameter int IN_SIZE     = 16,
    parameter int OUT_SIZE    = 16,
    parameter int BATCH_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // action[2:0] batch_slot[5:3] row_index[9:6]
                                  // col_index[13:10] value[29:14]
    input  logic        s_tuser,  // read_bias
    input  logic        s_tlast,  // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // result_value[31:0] index[35:32] kind[37:36]
    output logic        m_tlast   // end_of_run
);
    dlfb_cmd_t  cmd;
    dlfb_stat_t stat;

    dlfb_ctrl u_ctrl (.aclk, .aresetn, .s_tvalid, .s_tready, .stat, .cmd);

    dlfb_datapath #(.IN_SIZE(IN_SIZE), .OUT_SIZE(OUT_SIZE), .BATCH_SLOTS(BATCH_SLOTS))
        u_dp (.aclk, .aresetn, .s_tdata, .s_tuser, .s_tlast,
              .cmd, .stat,
              .m_tvalid, .m_tready, .m_tdata, .m_tlast);
endmodule
